// File: sv/i2c_master_transaction_engine_macros.svh
// Assertion macros for the I2C master transaction engine.
// Used by the top level only; needs clk and rst in scope.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_MACROS_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_MACROS_SVH
// Implication checked every clock outside reset.
`define I2CM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm check failed");
// Next-cycle implication checked every clock outside reset.
`define I2CM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm check failed");
`endif

// File: sv/i2cm_pkg.sv
// Package for the I2C master transaction engine: beat types, phase and op codes.
// No dependencies.
package i2cm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_START_C, PH_TX_LO1, PH_TX_HI, PH_TX_LO2,
    PH_ACK_LO, PH_ACK_HI, PH_ACK_TAIL, PH_RX_LO1, PH_RX_HI, PH_RX_LO2,
    PH_MACK_HI, PH_MACK_LO, PH_STOP_A, PH_STOP_B, PH_WAIT_TX
  } phase_t;

  typedef enum logic [2:0] {
    SG_ADDR, SG_MEMHI, SG_MEMLO, SG_ADDR_R, SG_DATA_TX, SG_DATA_RX
  } stage_t;

  localparam logic [2:0] OP_PROBE  = 3'd0;
  localparam logic [2:0] OP_REG_RD = 3'd1;
  localparam logic [2:0] OP_REG_WR = 3'd2;
  localparam logic [2:0] OP_RAW_RX = 3'd3;
  localparam logic [2:0] OP_RAW_TX = 3'd4;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_BEGIN = 2'd1;
  localparam logic [1:0] REQ_TXB   = 2'd2;

  localparam logic CFG_LOW  = 1'b0;
  localparam logic CFG_HIGH = 1'b1;

  localparam int unsigned POLL_STEP = 5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  op_kind;
    logic [6:0]  slave_addr;
    logic [15:0] mem_addr;
    logic        wide_mem_addr;
    logic        ignore_nack;
    logic        skip_start;
    logic        skip_stop;
    logic [15:0] byte_count;
    logic [7:0]  tx_byte;
    logic        sda_level;
  } in_beat_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       want_tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       done_res;
    logic       status;
  } out_beat_t;

endpackage

// File: sv/i2cm_timing.sv
// Phase length table: maps the current phase to its tick count from the clock settings.
// Depends on i2cm_pkg.
module i2cm_timing import i2cm_pkg::*; #(
  parameter int TIMER_WIDTH = 16
) (
  input  phase_t                 phase,
  input  logic [15:0]            clock_low_ticks,
  input  logic [15:0]            clock_high_ticks,
  output logic [TIMER_WIDTH-1:0] seg_len,
  output logic [TIMER_WIDTH-1:0] high_full
);
  localparam logic [16:0] TMAX = 17'((64'd1 << TIMER_WIDTH) - 64'd1);

  function automatic logic [TIMER_WIDTH-1:0] clampd(input logic [15:0] d);
    logic [16:0] v;
    v = {1'b0, d};
    if (v < 17'd1) v = 17'd1;
    if (v > TMAX) v = TMAX;
    return TIMER_WIDTH'(v);
  endfunction

  assign high_full = clampd(clock_high_ticks);

  // length lookup by phase
  always_comb begin
    case (phase)
      PH_START_A, PH_START_B, PH_STOP_B: seg_len = clampd(clock_high_ticks >> 1);
      PH_START_C, PH_TX_LO1, PH_TX_LO2, PH_ACK_LO, PH_ACK_TAIL, PH_RX_LO1,
      PH_RX_LO2, PH_STOP_A: seg_len = clampd(clock_low_ticks >> 1);
      PH_TX_HI, PH_RX_HI, PH_MACK_HI: seg_len = high_full;
      PH_MACK_LO: seg_len = clampd(clock_low_ticks);
      default: seg_len = TIMER_WIDTH'(1);
    endcase
  end
endmodule

// File: sv/i2cm_core.sv
// Bus sequencer: one step of the transaction state machine per accepted beat.
// Depends on i2cm_pkg and i2cm_timing.
module i2cm_core import i2cm_pkg::*; #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  in_beat_t    ib,
  input  logic [15:0] clock_low_ticks,
  input  logic [15:0] clock_high_ticks,
  output out_beat_t   ob
);
  // state
  phase_t phase, phase_next;
  stage_t stage, stage_next;
  logic [TIMER_WIDTH-1:0] tick_counter, tick_counter_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [2:0]  c_op, c_op_next;
  logic [6:0]  c_slave, c_slave_next;
  logic [15:0] c_mem, c_mem_next;
  logic        c_wide, c_wide_next, c_ign, c_ign_next, c_nostart, c_nostart_next;
  logic        c_nostop, c_nostop_next;
  logic        ack_seen, ack_seen_next, error_flag, error_flag_next;
  logic        drv_scl, drv_scl_next, drv_sda, drv_sda_next;

  logic [TIMER_WIDTH-1:0] seg_len, high_full;
  logic [TIMER_WIDTH:0]   poll_lim;
  logic [2:0]  poll_mod, poll_mod_next;
  logic        rxv, rxl, done;
  logic [7:0]  rxb;
  logic [15:0] bl_dec;
  logic [7:0]  sh;
  logic [3:0]  bc1;
  logic        raw, nack, fin_stop;

  i2cm_timing #(.TIMER_WIDTH(TIMER_WIDTH)) u_timing (
    .phase(phase), .clock_low_ticks(clock_low_ticks),
    .clock_high_ticks(clock_high_ticks), .seg_len(seg_len), .high_full(high_full)
  );

  // next-state logic; poll_mod tracks tick_counter mod 5 during ACK high
  always_comb begin
    phase_next = phase; stage_next = stage; tick_counter_next = tick_counter;
    bit_counter_next = bit_counter; shift_reg_next = shift_reg;
    bytes_left_next = bytes_left; c_op_next = c_op; c_slave_next = c_slave;
    c_mem_next = c_mem; c_wide_next = c_wide; c_ign_next = c_ign;
    c_nostart_next = c_nostart; c_nostop_next = c_nostop;
    ack_seen_next = ack_seen; error_flag_next = error_flag;
    drv_scl_next = drv_scl; drv_sda_next = drv_sda; poll_mod_next = poll_mod;
    rxv = 1'b0; rxb = '0; rxl = 1'b0; done = 1'b0;
    raw = (c_op == OP_RAW_RX) || (c_op == OP_RAW_TX);
    fin_stop = !(raw && c_nostop);
    nack = !ack_seen;
    bl_dec = bytes_left - 16'd1;
    sh = {shift_reg[6:0], 1'b0};
    bc1 = bit_counter + 4'd1;
    poll_lim = {1'b0, tick_counter} + (TIMER_WIDTH+1)'(POLL_STEP);
    case (phase)
      PH_IDLE: begin
        if (ib.req_type == REQ_BEGIN && ib.op_kind <= OP_RAW_TX) begin
          c_op_next = ib.op_kind; c_slave_next = ib.slave_addr;
          c_mem_next = ib.mem_addr; c_wide_next = ib.wide_mem_addr;
          c_ign_next = ib.ignore_nack; c_nostart_next = ib.skip_start;
          c_nostop_next = ib.skip_stop;
          error_flag_next = 1'b0; ack_seen_next = 1'b0;
          if (ib.op_kind == OP_REG_RD || ib.op_kind == OP_RAW_RX)
            bytes_left_next = (ib.byte_count == 16'd0) ? 16'd1 : ib.byte_count;
          else if (ib.op_kind == OP_PROBE) bytes_left_next = 16'd0;
          else bytes_left_next = ib.byte_count;
          tick_counter_next = '0;
          if ((ib.op_kind == OP_RAW_RX || ib.op_kind == OP_RAW_TX) && ib.skip_start) begin
            if (ib.op_kind == OP_RAW_RX) begin
              stage_next = SG_DATA_RX; shift_reg_next = '0; bit_counter_next = '0;
              phase_next = PH_RX_LO1; drv_scl_next = 1'b0; drv_sda_next = 1'b1;
            end else begin
              stage_next = SG_DATA_TX;
              if (ib.byte_count == 16'd0) begin
                if (ib.skip_stop) begin
                  phase_next = PH_IDLE; done = 1'b1;
                end else begin
                  phase_next = PH_STOP_A; drv_scl_next = 1'b0; drv_sda_next = 1'b0;
                end
              end else begin
                phase_next = PH_WAIT_TX; drv_scl_next = 1'b0;
              end
            end
          end else begin
            stage_next = SG_ADDR; phase_next = PH_START_A;
            drv_scl_next = 1'b1; drv_sda_next = 1'b1;
          end
        end
      end
      PH_WAIT_TX: begin
        if (ib.req_type == REQ_TXB) begin
          shift_reg_next = ib.tx_byte; bit_counter_next = '0; tick_counter_next = '0;
          phase_next = PH_TX_LO1; drv_scl_next = 1'b0; drv_sda_next = ib.tx_byte[7];
        end
      end
      PH_ACK_HI: begin
        if (poll_mod == 3'd0 && !ib.sda_level) begin
          ack_seen_next = 1'b1; phase_next = PH_ACK_TAIL; tick_counter_next = '0;
          drv_scl_next = 1'b0; drv_sda_next = 1'b1;
        end else if (poll_mod == 3'd0 && {1'b0, high_full} < poll_lim) begin
          ack_seen_next = 1'b0; phase_next = PH_ACK_TAIL; tick_counter_next = '0;
          drv_scl_next = 1'b0; drv_sda_next = 1'b1;
        end else begin
          tick_counter_next = tick_counter + TIMER_WIDTH'(1);
          // counter wraps to 0 at the timer limit, which restarts mod 5
          if (tick_counter == {TIMER_WIDTH{1'b1}}) poll_mod_next = 3'd0;
          else poll_mod_next = (poll_mod == 3'd4) ? 3'd0 : poll_mod + 3'd1;
        end
      end
      default: begin
        if ({1'b0, tick_counter} + (TIMER_WIDTH+1)'(1) < {1'b0, seg_len}) begin
          tick_counter_next = tick_counter + TIMER_WIDTH'(1);
        end else begin
          tick_counter_next = '0;
          case (phase)
            PH_START_A: begin
              phase_next = PH_START_B; drv_scl_next = 1'b1; drv_sda_next = 1'b0;
            end
            PH_START_B: begin
              phase_next = PH_START_C; drv_scl_next = 1'b0; drv_sda_next = 1'b0;
            end
            PH_START_C: begin
              shift_reg_next = {c_slave,
                                (stage == SG_ADDR_R) || (c_op == OP_RAW_RX)};
              bit_counter_next = '0; phase_next = PH_TX_LO1;
              drv_scl_next = 1'b0; drv_sda_next = c_slave[6];
            end
            PH_TX_LO1: begin phase_next = PH_TX_HI; drv_scl_next = 1'b1; end
            PH_TX_HI: begin phase_next = PH_TX_LO2; drv_scl_next = 1'b0; end
            PH_TX_LO2: begin
              bit_counter_next = bc1; shift_reg_next = sh; drv_scl_next = 1'b0;
              if (bc1 < 4'd8) begin
                phase_next = PH_TX_LO1; drv_sda_next = sh[7];
              end else begin
                phase_next = PH_ACK_LO; drv_sda_next = 1'b1;
              end
            end
            PH_ACK_LO: begin
              phase_next = PH_ACK_HI; drv_scl_next = 1'b1; drv_sda_next = 1'b1;
              poll_mod_next = 3'd0;
            end
            PH_ACK_TAIL: begin
              // after_ack decision, flattened to a few outcomes
              logic do_abort, do_finish, do_rx, do_tx, do_restart, do_data;
              logic [7:0] txv;
              logic err_set;
              do_abort = 1'b0; do_finish = 1'b0; do_rx = 1'b0; do_tx = 1'b0;
              do_restart = 1'b0; do_data = 1'b0; txv = '0; err_set = error_flag;
              case (stage)
                SG_ADDR: begin
                  if (c_op == OP_PROBE) begin err_set = nack; do_finish = 1'b1; end
                  else if (c_op == OP_REG_RD || c_op == OP_REG_WR) begin
                    if (nack) do_abort = 1'b1;
                    else if (c_wide) begin
                      stage_next = SG_MEMHI; do_tx = 1'b1; txv = c_mem[15:8];
                    end else begin
                      stage_next = SG_MEMLO; do_tx = 1'b1; txv = c_mem[7:0];
                    end
                  end else if (nack && !c_ign) do_abort = 1'b1;
                  else if (c_op == OP_RAW_RX) do_rx = 1'b1;
                  else do_data = 1'b1;
                end
                SG_MEMHI, SG_MEMLO: begin
                  if (nack && (c_op == OP_REG_RD || !c_ign)) do_abort = 1'b1;
                  else if (stage == SG_MEMHI) begin
                    stage_next = SG_MEMLO; do_tx = 1'b1; txv = c_mem[7:0];
                  end else if (c_op == OP_REG_RD) begin
                    stage_next = SG_ADDR_R; do_restart = 1'b1;
                  end else do_data = 1'b1;
                end
                SG_ADDR_R: begin
                  if (nack) do_abort = 1'b1; else do_rx = 1'b1;
                end
                default: begin
                  if (nack && !c_ign) do_abort = 1'b1;
                  else begin bytes_left_next = bl_dec; do_data = 1'b1; end
                end
              endcase
              if (do_abort) begin err_set = 1'b1; do_finish = 1'b1; end
              if (do_data) begin
                stage_next = SG_DATA_TX;
                if (((stage == SG_DATA_TX || stage == SG_DATA_RX) ? bl_dec : bytes_left)
                    == 16'd0) do_finish = 1'b1;
                else begin phase_next = PH_WAIT_TX; drv_scl_next = 1'b0; end
              end
              error_flag_next = err_set;
              if (do_tx) begin
                shift_reg_next = txv; bit_counter_next = '0; phase_next = PH_TX_LO1;
                drv_scl_next = 1'b0; drv_sda_next = txv[7];
              end
              if (do_rx) begin
                stage_next = SG_DATA_RX; shift_reg_next = '0; bit_counter_next = '0;
                phase_next = PH_RX_LO1; drv_scl_next = 1'b0; drv_sda_next = 1'b1;
              end
              if (do_restart) begin
                phase_next = PH_START_A; drv_scl_next = 1'b1; drv_sda_next = 1'b1;
              end
              if (do_finish) begin
                if (fin_stop) begin
                  phase_next = PH_STOP_A; drv_scl_next = 1'b0; drv_sda_next = 1'b0;
                end else begin
                  phase_next = PH_IDLE; done = 1'b1;
                end
              end
            end
            PH_RX_LO1: begin
              phase_next = PH_RX_HI; drv_scl_next = 1'b1; drv_sda_next = 1'b1;
            end
            PH_RX_HI: begin
              shift_reg_next = {shift_reg[6:0], ib.sda_level};
              bit_counter_next = bc1;
              if (bc1 >= 4'd8) begin
                rxv = 1'b1; rxb = {shift_reg[6:0], ib.sda_level};
                rxl = bytes_left <= 16'd1;
              end
              phase_next = PH_RX_LO2; drv_scl_next = 1'b0; drv_sda_next = 1'b1;
            end
            PH_RX_LO2: begin
              if (bit_counter < 4'd8) begin
                phase_next = PH_RX_LO1; drv_scl_next = 1'b0; drv_sda_next = 1'b1;
              end else begin
                phase_next = PH_MACK_HI; drv_scl_next = 1'b1;
                drv_sda_next = bytes_left <= 16'd1;
              end
            end
            PH_MACK_HI: begin phase_next = PH_MACK_LO; drv_scl_next = 1'b0; end
            PH_MACK_LO: begin
              bytes_left_next = bl_dec;
              if (bl_dec == 16'd0) begin
                if (fin_stop) begin
                  phase_next = PH_STOP_A; drv_scl_next = 1'b0; drv_sda_next = 1'b0;
                end else begin
                  phase_next = PH_IDLE; done = 1'b1;
                end
              end else begin
                stage_next = SG_DATA_RX; shift_reg_next = '0; bit_counter_next = '0;
                phase_next = PH_RX_LO1; drv_scl_next = 1'b0; drv_sda_next = 1'b1;
              end
            end
            PH_STOP_A: begin
              phase_next = PH_STOP_B; drv_scl_next = 1'b1; drv_sda_next = 1'b0;
            end
            default: begin
              phase_next = PH_IDLE; drv_scl_next = 1'b1; drv_sda_next = 1'b1;
              done = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  // state registers, advanced once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; stage <= SG_ADDR; tick_counter <= '0; bit_counter <= '0;
      shift_reg <= '0; bytes_left <= '0; c_op <= '0; c_slave <= '0; c_mem <= '0;
      c_wide <= 1'b0; c_ign <= 1'b0; c_nostart <= 1'b0; c_nostop <= 1'b0;
      ack_seen <= 1'b0; error_flag <= 1'b0; drv_scl <= 1'b1; drv_sda <= 1'b1;
      poll_mod <= '0;
    end else if (step) begin
      phase <= phase_next; stage <= stage_next; tick_counter <= tick_counter_next;
      bit_counter <= bit_counter_next; shift_reg <= shift_reg_next;
      bytes_left <= bytes_left_next; c_op <= c_op_next; c_slave <= c_slave_next;
      c_mem <= c_mem_next; c_wide <= c_wide_next; c_ign <= c_ign_next;
      c_nostart <= c_nostart_next; c_nostop <= c_nostop_next;
      ack_seen <= ack_seen_next; error_flag <= error_flag_next;
      drv_scl <= drv_scl_next; drv_sda <= drv_sda_next; poll_mod <= poll_mod_next;
    end
  end

  // result beat for this step
  always_comb begin
    ob.scl_drive    = drv_scl_next;
    ob.sda_drive    = drv_sda_next;
    ob.busy_res     = phase_next != PH_IDLE;
    ob.want_tx_byte = phase_next == PH_WAIT_TX;
    ob.rx_valid     = rxv;
    ob.rx_byte      = rxb;
    ob.rx_last      = rxl;
    ob.done_res     = done;
    ob.status       = done & error_flag_next;
  end
endmodule

// File: sv/i2c_master_transaction_engine.sv
// I2C master transaction engine: one input beat is one bus tick, one result beat each.
// A result beat is registered in the output register, or in the skid entry when the output stalls.
// Throughput: one beat per cycle while in_stall is low; a skid entry takes one more beat when the output stalls.
// The whole step is one pass of the sequencer logic between state and output registers.
// Reset (rst, synchronous): idle, both drives released, clocks at 500 ticks.
// Depends on i2cm_pkg, i2cm_core, i2cm_timing and the assertion macros header.
`include "i2c_master_transaction_engine_macros.svh"
module i2c_master_transaction_engine import i2cm_pkg::*; #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  logic [15:0] clock_low_ticks, clock_high_ticks;
  logic        step;
  out_beat_t   res;
  out_beat_t   skid;
  logic        skid_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_low_ticks <= 16'd500; clock_high_ticks <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW:  clock_low_ticks <= cfg_wdata;
        CFG_HIGH: clock_high_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign step     = in_valid && !in_stall;

  i2cm_core #(.TIMER_WIDTH(TIMER_WIDTH)) u_core (
    .clk(clk), .rst(rst), .step(step), .ib(in_data),
    .clock_low_ticks(clock_low_ticks), .clock_high_ticks(clock_high_ticks), .ob(res)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_valid <= 1'b1; skid_valid <= 1'b0;
        end else begin
          out_valid <= step;
        end
      end else if (step) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid : res;
    end
    if (step && out_valid && out_stall) skid <= res;
  end

  `I2CM_ASSERT_IMP(a_skid_full_out, skid_valid, out_valid)
  `I2CM_ASSERT_NXT(a_stall_holds, out_valid && out_stall, out_valid)
  `I2CM_ASSERT_IMP(a_done_idle, out_valid && out_data.done_res, !out_data.busy_res)
  `I2CM_ASSERT_IMP(a_want_busy, out_valid && out_data.want_tx_byte, out_data.busy_res)
endmodule
